@@ hw/rtl/lsc_pkg.sv @@
// Shared constants and types for the line segment clipper.
package lsc_pkg;

    // Default widths of coordinates and of the fixed-point clip parameter.
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Depth of the queue between the front and the back end.
    localparam int MID_DEPTH = 4;

    // Reset values of the window registers.
    localparam int WIN_LEFT_RESET   = 0;
    localparam int WIN_TOP_RESET    = 0;
    localparam int WIN_RIGHT_RESET  = 1023;
    localparam int WIN_BOTTOM_RESET = 1023;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_BOTTOM = 2'd3
    } cfg_index_t;

    // Window edges, in the order they are tested.
    localparam int NUM_EDGES   = 4;
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_TOP    = 2;
    localparam int EDGE_BOTTOM = 3;

    // Classification of one edge, worked out by the front end.
    typedef struct packed {
        logic p_neg;   // direction term is negative (entering edge)
        logic p_zero;  // segment runs parallel to the edge
        logic q_neg;   // distance term is negative
        logic ovf;     // ratio is at least four, so it saturates
    } edge_flags_t;

    localparam int FLAG_W = $bits(edge_flags_t);

endpackage

@@ hw/rtl/line_segment_clipper.sv @@
// Top level of the Liang-Barsky line segment clipper.
// Throughput: one segment per cycle unless stalled; one quotient bit per divider stage.
// A held result stalls the back end; the front end and its queue keep accepting until full.
// Reset clears all valid state and loads the window with 0, 0, 1023, 1023.
module line_segment_clipper
    import lsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         empty,
    input  logic                         pop,
    output logic                         visible,
    output logic signed [COORD_BITS-1:0] clip_start_x,
    output logic signed [COORD_BITS-1:0] clip_start_y,
    output logic signed [COORD_BITS-1:0] clip_end_x,
    output logic signed [COORD_BITS-1:0] clip_end_y
);

    localparam int ITEM_W = 2 * COORD_BITS + 8 * (COORD_BITS + 1) + NUM_EDGES * FLAG_W + 1;

    logic signed [COORD_BITS-1:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;
    logic                         front_ready;
    logic                         front_valid;
    logic [ITEM_W-1:0]            front_data;
    logic                         mid_full;
    logic                         mid_empty;
    logic                         mid_pop;
    logic [ITEM_W-1:0]            mid_data;

    // Window registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= COORD_BITS'(WIN_LEFT_RESET);
            win_top_reg    <= COORD_BITS'(WIN_TOP_RESET);
            win_right_reg  <= COORD_BITS'(WIN_RIGHT_RESET);
            win_bottom_reg <= COORD_BITS'(WIN_BOTTOM_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LEFT:   win_left_reg   <= cfg_data;
                CFG_TOP:    win_top_reg    <= cfg_data;
                CFG_RIGHT:  win_right_reg  <= cfg_data;
                CFG_BOTTOM: win_bottom_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign full = !front_ready;

    lsc_front #(
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .ready      (front_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .win_left   (win_left_reg),
        .win_top    (win_top_reg),
        .win_right  (win_right_reg),
        .win_bottom (win_bottom_reg),
        .item_valid (front_valid),
        .item_ready (!mid_full),
        .item_data  (front_data)
    );

    // Queue between the classifier and the arithmetic back end.
    lsc_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_data),
        .pop   (mid_pop),
        .rdata (mid_data),
        .full  (mid_full),
        .empty (mid_empty)
    );

    lsc_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (!mid_empty),
        .item_pop     (mid_pop),
        .item_data    (mid_data),
        .empty        (empty),
        .pop          (pop),
        .visible      (visible),
        .clip_start_x (clip_start_x),
        .clip_start_y (clip_start_y),
        .clip_end_x   (clip_end_x),
        .clip_end_y   (clip_end_y)
    );

    // The input side only backs up once the queue between the halves is full.
    a_full_needs_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> mid_full)
        else $error("input side full while the middle queue has room");

    // A hidden segment is reported with all clipped coordinates at zero.
    a_hidden_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !visible) |-> (clip_start_x == '0 && clip_start_y == '0 &&
                                  clip_end_x == '0 && clip_end_y == '0))
        else $error("hidden segment with non-zero coordinates");

    // The back end never takes from an empty queue.
    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty)
        else $error("back end took an item from an empty queue");

endmodule

@@ hw/rtl/lsc_queue.sv @@
// Small first-in first-out queue built from flip-flops.
module lsc_queue
    import lsc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = MID_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Transfers only happen when there is room or data.
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + AW'(1) : wptr_reg;
        rptr_next  = do_pop  ? rptr_reg + AW'(1) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/lsc_front.sv @@
// Front end: takes segments in and classifies them against the four window edges.
module lsc_front
    import lsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ITEM_W     = 2 * COORD_BITS + 8 * (COORD_BITS + 1) + NUM_EDGES * FLAG_W + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         ready,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] win_left,
    input  logic signed [COORD_BITS-1:0] win_top,
    input  logic signed [COORD_BITS-1:0] win_right,
    input  logic signed [COORD_BITS-1:0] win_bottom,
    output logic                         item_valid,
    input  logic                         item_ready,
    output logic [ITEM_W-1:0]            item_data
);

    localparam int CW      = COORD_BITS;
    localparam int W       = COORD_BITS + 1;
    localparam int OFF_FLG = 1;
    localparam int OFF_QM  = OFF_FLG + NUM_EDGES * FLAG_W;
    localparam int OFF_PM  = OFF_QM + NUM_EDGES * W;
    localparam int OFF_SY  = OFF_PM + NUM_EDGES * W;
    localparam int OFF_SX  = OFF_SY + CW;

    // Stage A holds the differences, stage B the magnitudes and flags.
    logic                 a_v_reg, a_v_next;
    logic                 b_v_reg, b_v_next;
    logic signed [CW-1:0] a_sx_reg, a_sy_reg;
    logic signed [W-1:0]  a_dx_reg, a_dy_reg;
    logic signed [W-1:0]  a_q_reg [NUM_EDGES];
    logic signed [CW-1:0] b_sx_reg, b_sy_reg;
    logic [W-1:0]         b_pm_reg [NUM_EDGES];
    logic [W-1:0]         b_qm_reg [NUM_EDGES];
    edge_flags_t          b_flg_reg [NUM_EDGES];
    logic                 b_rej_reg;

    logic signed [W-1:0]  p_val [NUM_EDGES];
    logic [W-1:0]         pm [NUM_EDGES];
    logic [W-1:0]         qm [NUM_EDGES];
    edge_flags_t          flg [NUM_EDGES];
    logic                 rej;
    logic                 in_fire;
    logic                 a_go;
    logic                 b_go;

    // Handshake: each stage moves on when the one after it has room.
    assign b_go    = b_v_reg && item_ready;
    assign a_go    = a_v_reg && (!b_v_reg || item_ready);
    assign ready   = !a_v_reg || !b_v_reg || item_ready;
    assign in_fire = push && ready;
    assign a_v_next = (a_v_reg && !a_go) || in_fire;
    assign b_v_next = (b_v_reg && !b_go) || a_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
        end
    end

    // Stage A: segment deltas and the distance of the start point to each edge.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_sx_reg <= start_x;
            a_sy_reg <= start_y;
            a_dx_reg <= W'(end_x) - W'(start_x);
            a_dy_reg <= W'(end_y) - W'(start_y);
            a_q_reg[EDGE_LEFT]   <= W'(start_x) - W'(win_left);
            a_q_reg[EDGE_RIGHT]  <= W'(win_right) - W'(start_x);
            a_q_reg[EDGE_TOP]    <= W'(start_y) - W'(win_top);
            a_q_reg[EDGE_BOTTOM] <= W'(win_bottom) - W'(start_y);
        end
    end

    // Direction terms, magnitudes and the classification of each edge.
    always_comb
    begin
        p_val[EDGE_LEFT]   = -a_dx_reg;
        p_val[EDGE_RIGHT]  = a_dx_reg;
        p_val[EDGE_TOP]    = -a_dy_reg;
        p_val[EDGE_BOTTOM] = a_dy_reg;
        rej = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            pm[e] = p_val[e][W-1] ? W'(-p_val[e]) : W'(p_val[e]);
            qm[e] = a_q_reg[e][W-1] ? W'(-a_q_reg[e]) : W'(a_q_reg[e]);
            flg[e].p_neg  = p_val[e][W-1];
            flg[e].p_zero = (p_val[e] == '0);
            flg[e].q_neg  = a_q_reg[e][W-1];
            flg[e].ovf    = ({2'b00, qm[e]} >= {pm[e], 2'b00});
            rej = rej || (flg[e].p_zero && flg[e].q_neg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            b_sx_reg  <= a_sx_reg;
            b_sy_reg  <= a_sy_reg;
            b_rej_reg <= rej;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                b_pm_reg[e]  <= pm[e];
                b_qm_reg[e]  <= qm[e];
                b_flg_reg[e] <= flg[e];
            end
        end
    end

    // Pack the classified segment for the queue.
    always_comb
    begin
        item_data = '0;
        item_data[0] = b_rej_reg;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            item_data[OFF_FLG + e*FLAG_W +: FLAG_W] = b_flg_reg[e];
            item_data[OFF_QM + e*W +: W]            = b_qm_reg[e];
            item_data[OFF_PM + e*W +: W]            = b_pm_reg[e];
        end
        item_data[OFF_SY +: CW] = b_sy_reg;
        item_data[OFF_SX +: CW] = b_sx_reg;
    end

    assign item_valid = b_v_reg;

endmodule

@@ hw/rtl/lsc_divider.sv @@
// Pipelined restoring divider giving a saturated-width fixed-point quotient.
module lsc_divider
#(
    parameter int NW = 17,
    parameter int FB = 16
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    output logic [FB+1:0] quo
);

    // One quotient bit per stage; the dividend is num shifted up by FB.
    localparam int QW = FB + 2;

    logic [NW-1:0] rem_reg [QW-1];
    logic [NW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];
    logic          low_reg;

    genvar i;
    for (i = 0; i < QW; i++)
    begin : g_stage
        logic [NW-1:0] rem_in;
        logic [NW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          nbit;
        logic [NW:0]   trial;

        if (i == 0)
        begin : g_first
            assign rem_in = num >> 2;
            assign den_in = den;
            assign quo_in = '0;
            assign nbit   = num[1];
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            if (i == 1)
            begin : g_low
                assign nbit = low_reg;
            end
            else
            begin : g_zero
                assign nbit = 1'b0;
            end
        end

        // Trial subtraction; a clear sign bit means the divisor fits.
        assign trial = {rem_in, nbit} - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= {quo_in[QW-2:0], ~trial[NW]};
            end
        end

        if (i < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= trial[NW] ? {rem_in[NW-2:0], nbit} : trial[NW-1:0];
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    // The lowest dividend bit above the fraction enters at the second stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            low_reg <= num[0];
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

@@ hw/rtl/lsc_back.sv @@
// Back end: divides, narrows the clip interval and interpolates the end points.
module lsc_back
    import lsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ITEM_W     = 2 * COORD_BITS + 8 * (COORD_BITS + 1) + NUM_EDGES * FLAG_W + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_pop,
    input  logic [ITEM_W-1:0]            item_data,
    output logic                         empty,
    input  logic                         pop,
    output logic                         visible,
    output logic signed [COORD_BITS-1:0] clip_start_x,
    output logic signed [COORD_BITS-1:0] clip_start_y,
    output logic signed [COORD_BITS-1:0] clip_end_x,
    output logic signed [COORD_BITS-1:0] clip_end_y
);

    localparam int CW      = COORD_BITS;
    localparam int FB      = FRAC_BITS;
    localparam int W       = COORD_BITS + 1;
    localparam int QW      = FB + 2;
    localparam int TW      = FB + 3;
    localparam int PW      = FB + 1 + W;
    localparam int OFF_FLG = 1;
    localparam int OFF_QM  = OFF_FLG + NUM_EDGES * FLAG_W;
    localparam int OFF_PM  = OFF_QM + NUM_EDGES * W;
    localparam int OFF_SY  = OFF_PM + NUM_EDGES * W;
    localparam int OFF_SX  = OFF_SY + CW;
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << FB;
    localparam logic [QW-1:0]        T_CAP = (QW'(1) << FB) + QW'(1);

    logic en;

    // Issue stage.
    logic                 i_v_reg;
    logic signed [CW-1:0] i_sx_reg, i_sy_reg;
    logic [W-1:0]         i_pm_reg [NUM_EDGES];
    logic [W-1:0]         i_qm_reg [NUM_EDGES];
    edge_flags_t          i_flg_reg [NUM_EDGES];
    logic                 i_rej_reg;

    // Side band that travels alongside the dividers.
    logic                 d_v_reg   [QW];
    logic signed [CW-1:0] d_sx_reg  [QW];
    logic signed [CW-1:0] d_sy_reg  [QW];
    logic [W-1:0]         d_dxm_reg [QW];
    logic [W-1:0]         d_dym_reg [QW];
    edge_flags_t          d_flg_reg [QW][NUM_EDGES];
    logic                 d_rej_reg [QW];
    logic [QW-1:0]        quo [NUM_EDGES];

    // Interval stage.
    logic                 s_v_reg;
    logic                 s_vis_reg;
    logic [FB:0]          s_t0_reg, s_t1_reg;
    logic signed [CW-1:0] s_sx_reg, s_sy_reg;
    logic [W-1:0]         s_dxm_reg, s_dym_reg;
    logic                 s_dxn_reg, s_dyn_reg;
    logic signed [TW-1:0] t0, t1;
    logic                 vis;

    // Multiply stage; points are start x, start y, end x, end y.
    logic                 m_v_reg;
    logic                 m_vis_reg;
    logic [W-1:0]         m_off_reg [4];
    logic                 m_neg_reg [4];
    logic signed [CW-1:0] m_base_reg [4];
    logic [PW-1:0]        prod [4];
    logic [FB:0]          pt_t [4];
    logic [W-1:0]         pt_d [4];
    logic                 pt_n [4];
    logic signed [CW-1:0] pt_s [4];

    // Output register.
    logic                 out_v_reg;
    logic                 out_vis_reg;
    logic signed [CW-1:0] out_pt_reg [4];
    logic signed [CW-1:0] res [4];

    // The whole back end advances together unless the result is held.
    assign en       = !out_v_reg || pop;
    assign item_pop = en && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_v_reg   <= 1'b0;
            s_v_reg   <= 1'b0;
            m_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k < QW; k++)
            begin
                d_v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            i_v_reg <= item_valid;
            d_v_reg[0] <= i_v_reg;
            for (int k = 1; k < QW; k++)
            begin
                d_v_reg[k] <= d_v_reg[k-1];
            end
            s_v_reg   <= d_v_reg[QW-1];
            m_v_reg   <= s_v_reg;
            out_v_reg <= m_v_reg;
        end
    end

    // Unpack the queued item into the issue stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_rej_reg <= item_data[0];
            i_sx_reg  <= item_data[OFF_SX +: CW];
            i_sy_reg  <= item_data[OFF_SY +: CW];
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                i_flg_reg[e] <= item_data[OFF_FLG + e*FLAG_W +: FLAG_W];
                i_qm_reg[e]  <= item_data[OFF_QM + e*W +: W];
                i_pm_reg[e]  <= item_data[OFF_PM + e*W +: W];
            end
        end
    end

    // One divider per edge works out q/p in fixed point.
    genvar g;
    for (g = 0; g < NUM_EDGES; g++)
    begin : g_div
        lsc_divider #(
            .NW (W),
            .FB (FB)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (i_qm_reg[g]),
            .den (i_pm_reg[g]),
            .quo (quo[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_sx_reg[0]  <= i_sx_reg;
            d_sy_reg[0]  <= i_sy_reg;
            d_dxm_reg[0] <= i_pm_reg[EDGE_RIGHT];
            d_dym_reg[0] <= i_pm_reg[EDGE_BOTTOM];
            d_rej_reg[0] <= i_rej_reg;
            d_flg_reg[0] <= i_flg_reg;
            for (int k = 1; k < QW; k++)
            begin
                d_sx_reg[k]  <= d_sx_reg[k-1];
                d_sy_reg[k]  <= d_sy_reg[k-1];
                d_dxm_reg[k] <= d_dxm_reg[k-1];
                d_dym_reg[k] <= d_dym_reg[k-1];
                d_rej_reg[k] <= d_rej_reg[k-1];
                d_flg_reg[k] <= d_flg_reg[k-1];
            end
        end
    end

    // Narrow the interval. Ratios beyond one plus one step are clamped, which
    // leaves the visibility decision and the kept end points unchanged.
    always_comb
    begin
        logic signed [TW-1:0] r;
        logic [QW-1:0]        m;
        t0 = '0;
        t1 = T_ONE;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            m = d_flg_reg[QW-1][e].ovf ? T_CAP : ((quo[e] > T_CAP) ? T_CAP : quo[e]);
            r = (d_flg_reg[QW-1][e].q_neg ^ d_flg_reg[QW-1][e].p_neg)
                ? -$signed({1'b0, m}) : $signed({1'b0, m});
            if (!d_flg_reg[QW-1][e].p_zero)
            begin
                if (d_flg_reg[QW-1][e].p_neg)
                begin
                    if (r > t0)
                    begin
                        t0 = r;
                    end
                end
                else if (r < t1)
                begin
                    t1 = r;
                end
            end
        end
        vis = !d_rej_reg[QW-1] && (t0 <= t1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_vis_reg <= vis;
            s_t0_reg  <= t0[FB:0];
            s_t1_reg  <= t1[FB:0];
            s_sx_reg  <= d_sx_reg[QW-1];
            s_sy_reg  <= d_sy_reg[QW-1];
            s_dxm_reg <= d_dxm_reg[QW-1];
            s_dym_reg <= d_dym_reg[QW-1];
            s_dxn_reg <= d_flg_reg[QW-1][EDGE_RIGHT].p_neg;
            s_dyn_reg <= d_flg_reg[QW-1][EDGE_BOTTOM].p_neg;
        end
    end

    // Offsets from the start point: t times the delta magnitude.
    always_comb
    begin
        pt_t[0] = s_t0_reg;  pt_d[0] = s_dxm_reg;  pt_n[0] = s_dxn_reg;  pt_s[0] = s_sx_reg;
        pt_t[1] = s_t0_reg;  pt_d[1] = s_dym_reg;  pt_n[1] = s_dyn_reg;  pt_s[1] = s_sy_reg;
        pt_t[2] = s_t1_reg;  pt_d[2] = s_dxm_reg;  pt_n[2] = s_dxn_reg;  pt_s[2] = s_sx_reg;
        pt_t[3] = s_t1_reg;  pt_d[3] = s_dym_reg;  pt_n[3] = s_dyn_reg;  pt_s[3] = s_sy_reg;
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = PW'(pt_t[k]) * PW'(pt_d[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_vis_reg <= s_vis_reg;
            for (int k = 0; k < 4; k++)
            begin
                m_off_reg[k]  <= W'(prod[k] >> FB);
                m_neg_reg[k]  <= pt_n[k];
                m_base_reg[k] <= pt_s[k];
            end
        end
    end

    // Apply the offset with the sign of the delta; a hidden segment gives zeros.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            res[k] = m_base_reg[k] + (m_neg_reg[k] ? -$signed(m_off_reg[k][CW-1:0])
                                                   : $signed(m_off_reg[k][CW-1:0]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vis_reg <= m_vis_reg;
            for (int k = 0; k < 4; k++)
            begin
                out_pt_reg[k] <= m_vis_reg ? res[k] : '0;
            end
        end
    end

    assign empty        = !out_v_reg;
    assign visible      = out_vis_reg;
    assign clip_start_x = out_pt_reg[0];
    assign clip_start_y = out_pt_reg[1];
    assign clip_end_x   = out_pt_reg[2];
    assign clip_end_y   = out_pt_reg[3];

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the Liang-Barsky line segment clipper.
`timescale 1ns / 100ps

module testbench;
    import lsc_pkg::*;

    localparam int CW      = 16;
    localparam int FB      = 16;
    localparam int LATENCY = FB + 8;
    localparam int WDOG    = 4000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic   vis;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } clip_result_t;

    // Scoreboard: holds the window and the clipped segments still owed.
    class clip_scoreboard;
        coord_t         win_l, win_t, win_r, win_b;
        clip_result_t   owed[$];
        int             errors;
        int             seen;
        int             shown;

        function new();
            win_l = coord_t'(WIN_LEFT_RESET);
            win_t = coord_t'(WIN_TOP_RESET);
            win_r = coord_t'(WIN_RIGHT_RESET);
            win_b = coord_t'(WIN_BOTTOM_RESET);
            errors = 0;
            seen = 0;
            shown = 0;
        endfunction

        function void set_window(cfg_index_t idx, coord_t v);
            case (idx)
                CFG_LEFT:   win_l = v;
                CFG_TOP:    win_t = v;
                CFG_RIGHT:  win_r = v;
                CFG_BOTTOM: win_b = v;
                default:    ;
            endcase
        endfunction

        // Fixed-point q/p, truncated toward zero.
        function longint ratio(longint q, longint p);
            longint unsigned mq, mp, m;
            mq = q < 0 ? -q : q;
            mp = p < 0 ? -p : p;
            m  = (mq << FB) / mp;
            return ((q < 0) != (p < 0)) ? -longint'(m) : longint'(m);
        endfunction

        function coord_t interp(longint s, longint d, longint t);
            longint unsigned m;
            longint off;
            m = (longint'(t) * (d < 0 ? -d : d)) >> FB;
            off = d < 0 ? -longint'(m) : longint'(m);
            return coord_t'(s + off);
        endfunction

        // Works out the clipped segment for one accepted transfer.
        function void note_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            longint p[4], q[4], dx, dy, t0, t1, r;
            bit ok;
            clip_result_t res;
            dx = longint'(ex) - sx;
            dy = longint'(ey) - sy;
            p[0] = -dx; q[0] = longint'(sx) - win_l;
            p[1] = dx;  q[1] = longint'(win_r) - sx;
            p[2] = -dy; q[2] = longint'(sy) - win_t;
            p[3] = dy;  q[3] = longint'(win_b) - sy;
            t0 = 0;
            t1 = longint'(1) << FB;
            ok = 1;
            for (int i = 0; i < 4; i++)
            begin
                if (p[i] == 0)
                begin
                    if (q[i] < 0)
                        ok = 0;
                end
                else
                begin
                    r = ratio(q[i], p[i]);
                    if (p[i] < 0 && r > t0)
                        t0 = r;
                    if (p[i] > 0 && r < t1)
                        t1 = r;
                end
            end
            if (t0 > t1)
                ok = 0;
            res = '0;
            if (ok)
            begin
                res.vis = 1'b1;
                res.sx = interp(sx, dx, t0);
                res.sy = interp(sy, dy, t0);
                res.ex = interp(sx, dx, t1);
                res.ey = interp(sy, dy, t1);
            end
            owed.push_back(res);
        endfunction

        // Compares one popped result with the oldest one owed.
        function void check_result(clip_result_t got);
            clip_result_t want;
            seen++;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, got);
                return;
            end
            want = owed.pop_front();
            if (want.vis) shown++;
            if (got.vis !== want.vis)
                report("visible", want.vis, got.vis);
            if (got.sx !== want.sx) report("clip_start_x", want.sx, got.sx);
            if (got.sy !== want.sy) report("clip_start_y", want.sy, got.sy);
            if (got.ex !== want.ex) report("clip_end_x", want.ex, got.ex);
            if (got.ey !== want.ey) report("clip_end_y", want.ey, got.ey);
        endfunction

        function void report(string fld, longint want, longint got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;
    logic   push = 1'b0;
    logic   full;
    coord_t start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic   empty;
    logic   pop = 1'b0;
    logic   visible;
    coord_t clip_start_x, clip_start_y, clip_end_x, clip_end_y;

    clip_scoreboard sb = new();
    int  push_idle_pct = 0;
    int  pop_idle_pct = 0;
    int  idle_cycles = 0;
    int  transfers_in = 0;
    bit  timed_out = 0;

    always #4 clk = ~clk;

    line_segment_clipper dut (.*);

    // Receiver: pops at random and checks each transfer at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result({visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y});
    end

    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_idle_pct);

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG && !timed_out)
        begin
            timed_out = 1;
            $display("%0t: watchdog expired, %0d results outstanding", $time, sb.owed.size());
            $display("** line_segment_clipper: FAILED **");
            $finish;
        end
    end

    // Window write while idle.
    task automatic write_window(cfg_index_t idx, coord_t v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_window(idx, v);
    endtask

    task automatic set_window4(coord_t l, coord_t t, coord_t r, coord_t b);
        write_window(CFG_LEFT, l);
        write_window(CFG_TOP, t);
        write_window(CFG_RIGHT, r);
        write_window(CFG_BOTTOM, b);
    endtask

    // Offers one segment, holding push until the transfer happens. Push stays
    // high afterwards so that the next segment can follow without a gap.
    task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        @(negedge clk);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_segment(sx, sy, ex, ey);
        transfers_in++;
    endtask

    // Stops offering segments.
    task automatic stop_sending();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(coord_t lo, coord_t hi);
        int span;
        span = int'(hi) - int'(lo);
        case ($urandom_range(3))
            0: return coord_t'($urandom());
            default: return coord_t'(int'(lo) - span / 2 + int'($urandom_range(2 * span + 2)));
        endcase
    endfunction

    task automatic random_segments(int n);
        coord_t lo_x, hi_x, lo_y, hi_y, sx, sy;
        lo_x = sb.win_l; hi_x = sb.win_r; lo_y = sb.win_t; hi_y = sb.win_b;
        if (lo_x > hi_x) begin lo_x = sb.win_r; hi_x = sb.win_l; end
        if (lo_y > hi_y) begin lo_y = sb.win_b; hi_y = sb.win_t; end
        for (int i = 0; i < n; i++)
        begin
            sx = rand_coord(lo_x, hi_x);
            sy = rand_coord(lo_y, hi_y);
            case ($urandom_range(7))
                0: send_segment(sx, sy, sx, sy);
                1: send_segment(sx, sy, sx, rand_coord(lo_y, hi_y));
                2: send_segment(sx, sy, rand_coord(lo_x, hi_x), sy);
                default: send_segment(sx, sy, rand_coord(lo_x, hi_x), rand_coord(lo_y, hi_y));
            endcase
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed segments against the reset window.
        push_idle_pct = 0;
        pop_idle_pct = 0;
        send_segment(10, 10, 100, 200);             // wholly inside
        send_segment(-100, 500, 2000, 500);         // crosses left and right
        send_segment(500, -100, 500, 2000);         // crosses top and bottom
        send_segment(-50, -50, -10, -10);           // wholly outside
        send_segment(300, 300, 300, 300);           // point inside
        send_segment(1023, 1023, 1023, 1023);       // point on the corner
        send_segment(1024, 5, 1024, 5);             // point just outside
        send_segment(-10, 5, -10, 900);             // parallel, outside left
        send_segment(2000, 2000, -2000, -2000);     // reversed diagonal
        send_segment(-32768, -32768, 32767, 32767); // coordinate extremes
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-1, 1024, 1024, -1);           // crosses corner to corner
        send_segment(0, 0, 1023, 0);                // along the top edge
        drain();

        // Inverted window rejects everything.
        set_window4(100, 100, -100, -100);
        send_segment(0, 0, 0, 0);
        send_segment(-500, -500, 500, 500);
        drain();

        // Whole coordinate range as window.
        set_window4(-32768, -32768, 32767, 32767);
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(-32768, -32768, -32768, -32768);
        send_segment(32767, 32767, 32767, 32767);
        drain();

        // Random phases, each with its own window; the idling mix changes every two phases.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_window4(0, 0, 1023, 1023);
                1: set_window4(-200, 50, 300, 60);
                2: set_window4(-32768, -32768, 32767, 32767);
                3: set_window4(-5, -5, 5, 5);
                4: set_window4(coord_t'($urandom()), coord_t'($urandom()),
                               coord_t'($urandom()), coord_t'($urandom()));
                default: set_window4(7, 7, 7, 7);
            endcase
            push_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 85 : 0;
            pop_idle_pct  = (ph < 2) ? 85 : (ph < 4) ? 22 : 0;
            random_segments(100);
            // Sender holds off until every result has come back.
            stop_sending();
            while (sb.owed.size() != 0)
                @(posedge clk);
            random_segments(100);
            drain();
        end

        $display("Clipped %0d segments over several windows, %0d visible, %0d results checked.",
                 transfers_in, sb.shown, sb.seen);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("** line_segment_clipper: PASSED **");
        else
            $display("** line_segment_clipper: FAILED **");
        $finish;
    end
endmodule

@@ line_segment_clipper.f @@
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_queue.sv
hw/rtl/lsc_front.sv
hw/rtl/lsc_divider.sv
hw/rtl/lsc_back.sv
hw/rtl/line_segment_clipper.sv
bench/testbench.sv
